FILE: sv/rfa_pkg.sv
// Shared types and constants for the image rotate/flip address generator.
// No dependencies; used by every module of the block.
package rfa_pkg;

    localparam int unsigned CFG_W    = 13;   // widest configuration register
    localparam int unsigned DIM_W    = 13;   // width, height and coordinates
    localparam int unsigned PITCH_W  = 15;   // row pitch and x byte offset
    localparam int unsigned ADDR_W   = 26;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [IDX_W-1:0] REG_BPP    = 2'd3;

    localparam logic [2:0] MODE_ROT90CW   = 3'd0;
    localparam logic [2:0] MODE_ROT90CCW  = 3'd1;
    localparam logic [2:0] MODE_ROT180    = 3'd2;
    localparam logic [2:0] MODE_HFLIP     = 3'd3;
    localparam logic [2:0] MODE_VFLIP     = 3'd4;
    localparam logic [2:0] MODE_TRANSPOSE = 3'd5;
    localparam logic [2:0] MODE_ANTIDIAG  = 3'd6;

    typedef struct packed {
        logic [2:0]       mode;
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
        logic [2:0]       bytes_per_pixel;
    } t_cfg;

    typedef struct packed {
        logic [DIM_W-1:0]   dest_y;
        logic [PITCH_W-1:0] pitch;
        logic [PITCH_W-1:0] dx_bytes;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } t_stage;

endpackage

FILE: sv/rfa_coord.sv
// Source column/row counters and transform stage: dest coordinates and pitch.
// Depends on rfa_pkg.
module rfa_coord #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rfa_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rfa_pkg::PIXEL_W-1:0]  i_pixel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output rfa_pkg::t_stage              o_stage
);

    localparam int unsigned DW    = rfa_pkg::DIM_W;
    localparam int unsigned DMAX  = (1 << DW) - 1;
    localparam int unsigned CNT_X_W = (MAX_WIDTH > DMAX) ? DW :
                                      ((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1);
    localparam int unsigned CNT_Y_W = (MAX_HEIGHT > DMAX) ? DW :
                                      ((MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1);
    localparam logic [DW-1:0] LIM_W = (MAX_WIDTH > DMAX)  ? DW'(DMAX) : DW'(MAX_WIDTH);
    localparam logic [DW-1:0] LIM_H = (MAX_HEIGHT > DMAX) ? DW'(DMAX) : DW'(MAX_HEIGHT);

    function automatic logic [rfa_pkg::PITCH_W-1:0] mul_bpp(
        input logic [DW-1:0] v,
        input logic [2:0]    bpp
    );
        logic [rfa_pkg::PITCH_W-1:0] ve;
        logic [rfa_pkg::PITCH_W-1:0] res;
        ve = rfa_pkg::PITCH_W'(v);
        unique case (bpp)
            3'd1:    res = ve;
            3'd2:    res = ve << 1;
            3'd3:    res = ve + (ve << 1);
            default: res = ve << 2;
        endcase
        return res;
    endfunction

    logic [CNT_X_W-1:0] r_col, n_col;
    logic [CNT_Y_W-1:0] r_row, n_row;
    logic               r_valid;
    rfa_pkg::t_stage    r_stage, n_stage;

    logic [DW-1:0] w, h, w_m1, h_m1, x, y, xr, yr, dx, dy, dw;
    logic [2:0]    bpp;
    logic          restart, accept, end_col, end_row;
    logic [rfa_pkg::PITCH_W-1:0] row_bytes;

    always_comb begin
        priority if (i_cfg.src_width == '0) begin
            w = DW'(1);
        end else if (i_cfg.src_width > LIM_W) begin
            w = LIM_W;
        end else begin
            w = i_cfg.src_width;
        end
        priority if (i_cfg.src_height == '0) begin
            h = DW'(1);
        end else if (i_cfg.src_height > LIM_H) begin
            h = LIM_H;
        end else begin
            h = i_cfg.src_height;
        end
        priority if (i_cfg.bytes_per_pixel == 3'd0) begin
            bpp = 3'd1;
        end else if (i_cfg.bytes_per_pixel > 3'd4) begin
            bpp = 3'd4;
        end else begin
            bpp = i_cfg.bytes_per_pixel;
        end

        w_m1    = w - DW'(1);
        h_m1    = h - DW'(1);
        restart = (DW'(r_col) >= w) || (DW'(r_row) >= h);
        x       = restart ? '0 : DW'(r_col);
        y       = restart ? '0 : DW'(r_row);
        xr      = w_m1 - x;
        yr      = h_m1 - y;
        end_col = (x == w_m1);
        end_row = (y == h_m1);

        unique case (i_cfg.mode)
            rfa_pkg::MODE_ROT90CW:   begin dx = yr; dy = x;  dw = h; end
            rfa_pkg::MODE_ROT90CCW:  begin dx = y;  dy = xr; dw = h; end
            rfa_pkg::MODE_ROT180:    begin dx = xr; dy = yr; dw = w; end
            rfa_pkg::MODE_HFLIP:     begin dx = xr; dy = y;  dw = w; end
            rfa_pkg::MODE_VFLIP:     begin dx = x;  dy = yr; dw = w; end
            rfa_pkg::MODE_TRANSPOSE: begin dx = y;  dy = x;  dw = h; end
            rfa_pkg::MODE_ANTIDIAG:  begin dx = yr; dy = xr; dw = h; end
            default:                 begin dx = x;  dy = y;  dw = w; end
        endcase

        // pitch rounds the row up to a 4-byte multiple
        row_bytes = mul_bpp(dw, bpp);

        n_stage.dest_y   = dy;
        n_stage.pitch    = (row_bytes + rfa_pkg::PITCH_W'(3)) & ~rfa_pkg::PITCH_W'(3);
        n_stage.dx_bytes = mul_bpp(dx, bpp);
        n_stage.pixel    = i_pixel;
        n_stage.last     = end_col && end_row;

        n_col = end_col ? '0 : CNT_X_W'(x + DW'(1));
        n_row = end_col ? (end_row ? '0 : CNT_Y_W'(y + DW'(1))) : CNT_Y_W'(y);
    end

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: sv/rfa_addr.sv
// Address stage: dest_y * pitch + x byte offset into the output register.
// Depends on rfa_pkg.
module rfa_addr (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  rfa_pkg::t_stage              i_stage,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rfa_pkg::ADDR_W-1:0]   o_addr,
    output logic [rfa_pkg::PIXEL_W-1:0]  o_pixel,
    output logic                         o_last
);

    localparam int unsigned PW = rfa_pkg::DIM_W + rfa_pkg::PITCH_W;

    logic [PW-1:0]                row_off;
    logic [rfa_pkg::ADDR_W-1:0]   n_addr;
    logic [rfa_pkg::ADDR_W-1:0]   r_addr;
    logic [rfa_pkg::PIXEL_W-1:0]  r_pixel;
    logic                         r_last;
    logic                         r_valid;

    assign row_off = PW'(i_stage.dest_y) * PW'(i_stage.pitch);
    assign n_addr  = row_off[rfa_pkg::ADDR_W-1:0] + rfa_pkg::ADDR_W'(i_stage.dx_bytes);
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_addr  <= n_addr;
            r_pixel <= i_stage.pixel;
            r_last  <= i_stage.last;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

endmodule

FILE: sv/image_rotate_flip_address_gen_unit.sv
// Image rotate/flip address generator: takes source pixels in raster order, counts
// column and row itself, and gives each pixel's byte offset in the padded
// destination buffer of the configured rotation, flip or transpose. One pixel is
// accepted per clock while the output is not back-pressured; a pixel's result passes
// the transform register, then the multiply-add output register, and both stages
// stall in place on back-pressure. Destination pitch is the destination width
// times bytes per pixel rounded up to four bytes; addresses wrap at 2^26.
// The user must write configuration only while no pixels are in flight; the
// block itself does not enforce it. Depends on rfa_pkg, rfa_coord and rfa_addr.
module image_rotate_flip_address_gen_unit #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rfa_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [rfa_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [31:0]                  i_s_tdata,   // [31:0] pixel_in
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [63:0]                  o_m_tdata,   // [25:0] dest_address, [57:26] pixel_out
    output logic                         o_m_tlast    // last_pixel
);

    rfa_pkg::t_cfg   r_cfg;
    rfa_pkg::t_stage stage;
    logic            stage_valid, stage_ready;
    logic [rfa_pkg::ADDR_W-1:0]  addr;
    logic [rfa_pkg::PIXEL_W-1:0] pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= rfa_pkg::MODE_ROT90CW;
            r_cfg.src_width       <= rfa_pkg::DIM_W'(1);
            r_cfg.src_height      <= rfa_pkg::DIM_W'(1);
            r_cfg.bytes_per_pixel <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rfa_pkg::REG_MODE:   r_cfg.mode            <= i_cfg_data[2:0];
                rfa_pkg::REG_WIDTH:  r_cfg.src_width       <= i_cfg_data;
                rfa_pkg::REG_HEIGHT: r_cfg.src_height      <= i_cfg_data;
                default:             r_cfg.bytes_per_pixel <= i_cfg_data[2:0];
            endcase
        end
    end

    rfa_coord #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_pixel (i_s_tdata),
        .o_valid (stage_valid),
        .i_ready (stage_ready),
        .o_stage (stage)
    );

    rfa_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid),
        .o_ready (stage_ready),
        .i_stage (stage),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_addr  (addr),
        .o_pixel (pixel),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, pixel, addr};

    // input stalls only when both stages are full
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (stage_valid && o_m_tvalid))
        else $error("input stalled with a free stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> stage_valid)
        else $error("accepted item missing from transform stage");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && !stage_ready) |=> (stage_valid && $stable(stage)))
        else $error("transform stage changed while stalled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && stage_ready) |=> o_m_tvalid)
        else $error("item lost between stages");

endmodule
